[src/assert_macros.svh]
// Assertion macros used by the deque checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle implication");

`endif

[src/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types, codes and defaults shared by the deque controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_in;
    } dq_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] removed_value;
        logic [7:0] front_value;
        logic [7:0] back_value;
        logic [4:0] entry_total;
    } dq_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } dq_ctl_t;

endpackage

[src/dq_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_controller
// Sequences one request through capture, execute and publish.
// ----------------------------------------------------------------------------
module dq_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            request_valid,
    output logic            request_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output dq_pkg::dq_ctl_t ctl
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free      = !out_valid_reg || !result_stall;
    assign request_stall = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        ctl.publish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (request_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.execute = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/dq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Slot memory, head and count registers, cached end bytes, result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dq_pkg::dq_ctl_t ctl,
    input  dq_pkg::dq_req_t request,
    output dq_pkg::dq_rsp_t result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_WIDE = (CNT_W + 1)'(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;

    dq_pkg::dq_req_t  req_reg;
    logic [PTR_W-1:0] head_reg,  head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       front_reg, front_next;
    logic [7:0]       back_reg,  back_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       removed_reg, removed_next;
    logic             load_front_reg, load_front_next;
    logic             load_back_reg,  load_back_next;
    dq_pkg::dq_rsp_t  result_reg, result_next;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    logic             is_empty;
    logic             is_full;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;
    logic [CNT_W-1:0] count_dec;
    logic [7:0]       front_fin;
    logic [7:0]       back_fin;

    // Slot at a given offset from the head, offset below DEPTH.
    function automatic logic [PTR_W-1:0] slot_at(
        input logic [PTR_W-1:0] base,
        input logic [CNT_W-1:0] offset
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= DEPTH_WIDE)
        begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_COUNT);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign front_fin = load_front_reg ? rd_data_reg : front_reg;
    assign back_fin  = load_back_reg  ? rd_data_reg : back_reg;
    assign result    = result_reg;

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        load_front_next = load_front_reg;
        load_back_next  = load_back_reg;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        if (ctl.execute)
        begin
            status_next     = dq_pkg::STATUS_DONE;
            removed_next    = '0;
            load_front_next = 1'b0;
            load_back_next  = 1'b0;
            case (req_reg.command)
                dq_pkg::CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        count_next = count_reg + 1'b1;
                        front_next = req_reg.data_in;
                        if (is_empty)
                        begin
                            back_next = req_reg.data_in;
                        end
                    end
                end
                dq_pkg::CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = slot_at(head_reg, count_reg);
                        count_next = count_reg + 1'b1;
                        back_next  = req_reg.data_in;
                        if (is_empty)
                        begin
                            front_next = req_reg.data_in;
                        end
                    end
                end
                dq_pkg::CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        removed_next    = front_reg;
                        head_next       = head_inc;
                        count_next      = count_dec;
                        // fetch the new front entry
                        rd_en           = 1'b1;
                        rd_addr         = head_inc;
                        load_front_next = (count_dec != '0);
                    end
                end
                dq_pkg::CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        removed_next   = back_reg;
                        count_next     = count_dec;
                        // fetch the new back entry
                        rd_en          = 1'b1;
                        rd_addr        = slot_at(head_reg, count_reg - 2'd2);
                        load_back_next = (count_dec != '0);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
        else if (ctl.publish)
        begin
            front_next                = front_fin;
            back_next                 = back_fin;
            load_front_next           = 1'b0;
            load_back_next            = 1'b0;
            result_next.status        = status_reg;
            result_next.removed_value = removed_reg;
            result_next.front_value   = is_empty ? 8'd0 : front_fin;
            result_next.back_value    = is_empty ? 8'd0 : back_fin;
            result_next.entry_total   = 5'(count_reg);
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_reg.data_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= request;
        end
        front_reg   <= front_next;
        back_reg    <= back_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            load_front_reg <= 1'b0;
            load_back_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            load_front_reg <= load_front_next;
            load_back_reg  <= load_back_next;
        end
    end

endmodule

[src/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Byte deque in a ring of DEPTH slots, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (request_valid / request_stall / request) carries a
//   command (push front, push back, pop front, pop back) and a data byte.
//   result channel (result_valid / result_stall / result) returns, for every
//   request, the status, the popped byte, the front and back bytes and the
//   entry count after the command.
// Timing:
//   a request is captured, executed, then published into the result
//   register once the result side can take it; the next request is taken
//   only after the last is published. Execute writes the single slot
//   memory or launches its registered read of the new end byte; publish
//   folds that byte into the cached front/back registers and result register.
//   request_stall is high while a request is in progress.
// Reset:
//   clears the head index, the entry count and all valid state; the queue
//   reads empty. Slot contents are not cleared.
// Back-pressure:
//   while result_stall is high the result holds; the next request is still
//   accepted and worked up to the point of publishing, then waits.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            request_valid,
    output logic            request_stall,
    input  dq_pkg::dq_req_t request,
    output logic            result_valid,
    input  logic            result_stall,
    output dq_pkg::dq_rsp_t result
);

    // Commands from the sequencer into the datapath.
    dq_pkg::dq_ctl_t ctl;

    // Sequencer: idle -> execute -> publish, one request at a time.
    dq_controller u_controller (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .ctl           (ctl)
    );

    // Storage, index arithmetic and the result register.
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .result  (result)
    );

endmodule

[src/dq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            result_valid,
    input logic            result_stall,
    input dq_pkg::dq_rsp_t result
);

    logic shows_empty;
    logic ends_zero;
    logic shows_fail;
    logic shows_underflow;

    assign shows_empty     = result_valid && (result.entry_total == 5'd0);
    assign ends_zero       = (result.front_value == 8'd0) && (result.back_value == 8'd0);
    assign shows_fail      = result_valid && (result.status != dq_pkg::STATUS_DONE);
    assign shows_underflow = result_valid && (result.status == dq_pkg::STATUS_UNDERFLOW);

    // a stalled result holds
    `DQ_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid)
    `DQ_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall, $stable(result))

    // an empty queue shows zero end bytes
    `DQ_ASSERT_NOW(a_empty_ends, clk, rst_n, shows_empty, ends_zero)

    // failed commands remove nothing; underflow only on empty
    `DQ_ASSERT_NOW(a_fail_nothing, clk, rst_n, shows_fail, (result.removed_value == 8'd0))
    `DQ_ASSERT_NOW(a_underflow_empty, clk, rst_n, shows_underflow, (result.entry_total == 5'd0))

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
);
